/* src/ocmc_pkg.sv */
package ocmc_pkg;

  // command codes of the input channel
  localparam logic CMD_PRELOAD = 1'b0;
  localparam logic CMD_ACCESS  = 1'b1;

  // result and register constants
  localparam int          CAP_W     = 7;
  localparam logic [10:0] TALLY_MAX = 11'h7FF;
  localparam logic [6:0]  CAP_RESET = 7'd64;

  // sequencer states, one-hot
  typedef enum logic [14:0] {
    ST_IDLE    = 15'h0001,
    ST_PRE_CHK = 15'h0002,
    ST_PRE_CMP = 15'h0004,
    ST_NU_I    = 15'h0008,
    ST_NU_ID   = 15'h0010,
    ST_NU_J    = 15'h0020,
    ST_NU_JC   = 15'h0040,
    ST_RN_S    = 15'h0080,
    ST_RN_ID   = 15'h0100,
    ST_RP_I    = 15'h0200,
    ST_RP_ID   = 15'h0400,
    ST_RP_F    = 15'h0800,
    ST_RP_FC   = 15'h1000,
    ST_RP_M    = 15'h2000,
    ST_RP_MC   = 15'h4000
  } state_t;

endpackage

/* src/ocmc_ram.sv */
module ocmc_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/optimal_cache_miss_counter_core.sv */
// Channel  | Ports                                   | Transfer
// ---------+-----------------------------------------+------------------------------
// input    | in_command, in_item_id, in_last         | start && !busy at clk edge
// result   | out_miss_count, out_overflow            | out_valid, one cycle
// config   | cfg_wdata (cache_capacity)              | cfg_we at clk edge
//
// An access without last is taken in ST_IDLE, so busy stays low. A preload scans
// the resident slots through ST_PRE_CHK and ST_PRE_CMP and holds busy meanwhile.
// After last the sequencer runs over the memories through one read port each:
// a next-use pass, a resident pass and a replay, one after another.
// rst_n is synchronous, active low; it empties the job and sets capacity 64.
// The receiver cannot stall: out_valid is a single-cycle strobe.
module optimal_cache_miss_counter_core #(
  parameter int SEQ_DEPTH   = 1024,
  parameter int CACHE_DEPTH = 64,
  parameter int ID_WIDTH    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [31:0] in_item_id,
  input  logic        in_last,
  output logic        out_valid,
  output logic [10:0] out_miss_count,
  output logic        out_overflow,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata
);

  import ocmc_pkg::*;

  localparam int IDW = (ID_WIDTH < 32) ? ID_WIDTH : 32;
  localparam int SW  = $clog2(SEQ_DEPTH + 1);
  localparam int SA  = $clog2(SEQ_DEPTH);
  localparam int CW  = $clog2(CACHE_DEPTH + 1);
  localparam int CA  = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int KW  = (CW > CAP_W) ? CW : CAP_W;

  state_t           state_r, state_nxt;
  logic [SW-1:0]    i_r, i_nxt, j_r, j_nxt, len_r, len_nxt;
  logic [CW-1:0]    s_r, s_nxt, occ_r, occ_nxt;
  logic [CA-1:0]    best_r, best_nxt;
  logic [SW-1:0]    far_r, far_nxt, cur_nu_r, cur_nu_nxt;
  logic [IDW-1:0]   tgt_r, tgt_nxt;
  logic [10:0]      tally_r, tally_nxt;
  logic             ovf_r, ovf_nxt, have_r, have_nxt, mode_r, mode_nxt;
  logic             last_r, last_nxt;
  logic [6:0]       cap_r;
  logic             ov_r, ov_nxt;
  logic [10:0]      omc_r, omc_nxt;
  logic             oof_r, oof_nxt;

  // memory ports
  logic             acc_we, nu_we, rid_we, rnu_we;
  logic [SA-1:0]    acc_waddr, acc_raddr, nu_waddr, nu_raddr;
  logic [CA-1:0]    rid_waddr, rid_raddr, rnu_waddr, rnu_raddr;
  logic [IDW-1:0]   acc_rdata, rid_rdata, rid_wdata;
  logic [SW-1:0]    nu_rdata, nu_wdata, rnu_rdata, rnu_wdata;

  logic [IDW-1:0]   in_id;
  logic [KW-1:0]    cap_eff;
  logic [SW-1:0]    scan_val;

  assign in_id = in_item_id[IDW-1:0];
  assign busy  = (state_r != ST_IDLE);

  // capacity zero acts as one, above storage acts as storage depth
  always_comb begin
    cap_eff = KW'(cap_r);
    if (cap_r == 7'd0) begin
      cap_eff = KW'(1);
    end
    if (cap_eff > KW'(CACHE_DEPTH)) begin
      cap_eff = KW'(CACHE_DEPTH);
    end
  end

  ocmc_ram #(.DEPTH(SEQ_DEPTH), .WIDTH(IDW), .AW(SA)) u_acc (
    .clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(tgt_nxt),
    .raddr(acc_raddr), .rdata(acc_rdata));
  ocmc_ram #(.DEPTH(SEQ_DEPTH), .WIDTH(SW), .AW(SA)) u_nu (
    .clk(clk), .we(nu_we), .waddr(nu_waddr), .wdata(nu_wdata),
    .raddr(nu_raddr), .rdata(nu_rdata));
  ocmc_ram #(.DEPTH(CACHE_DEPTH), .WIDTH(IDW), .AW(CA)) u_rid (
    .clk(clk), .we(rid_we), .waddr(rid_waddr), .wdata(rid_wdata),
    .raddr(rid_raddr), .rdata(rid_rdata));
  ocmc_ram #(.DEPTH(CACHE_DEPTH), .WIDTH(SW), .AW(CA)) u_rnu (
    .clk(clk), .we(rnu_we), .waddr(rnu_waddr), .wdata(rnu_wdata),
    .raddr(rnu_raddr), .rdata(rnu_rdata));

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    len_nxt    = len_r;
    s_nxt      = s_r;
    occ_nxt    = occ_r;
    best_nxt   = best_r;
    far_nxt    = far_r;
    cur_nu_nxt = cur_nu_r;
    tgt_nxt    = tgt_r;
    tally_nxt  = tally_r;
    ovf_nxt    = ovf_r;
    have_nxt   = have_r;
    mode_nxt   = mode_r;
    last_nxt   = last_r;
    ov_nxt     = 1'b0;
    omc_nxt    = omc_r;
    oof_nxt    = oof_r;
    acc_we     = 1'b0;
    acc_waddr  = len_r[SA-1:0];
    acc_raddr  = i_r[SA-1:0];
    nu_we      = 1'b0;
    nu_waddr   = i_r[SA-1:0];
    nu_wdata   = len_r;
    nu_raddr   = i_r[SA-1:0];
    rid_we     = 1'b0;
    rid_waddr  = occ_r[CA-1:0];
    rid_wdata  = tgt_r;
    rid_raddr  = s_r[CA-1:0];
    rnu_we     = 1'b0;
    rnu_waddr  = s_r[CA-1:0];
    rnu_wdata  = cur_nu_r;
    rnu_raddr  = s_r[CA-1:0];
    scan_val   = len_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          tgt_nxt  = in_id;
          last_nxt = in_last;
          s_nxt    = '0;
          i_nxt    = '0;
          if (in_command == CMD_PRELOAD) begin
            state_nxt = ST_PRE_CHK;
          end else begin
            if (len_r >= SW'(SEQ_DEPTH)) begin
              ovf_nxt = 1'b1;
            end else begin
              acc_we  = 1'b1;
              len_nxt = len_r + 1'b1;
            end
            if (in_last) begin
              state_nxt = ST_NU_I;
            end
          end
        end
      end

      // duplicate check over resident slots, then append, or flag overflow if full
      ST_PRE_CHK: begin
        if (s_r == occ_r) begin
          if (occ_r >= CW'(CACHE_DEPTH)) begin
            ovf_nxt = 1'b1;
          end else begin
            rid_we  = 1'b1;
            occ_nxt = occ_r + 1'b1;
          end
          state_nxt = last_r ? ST_NU_I : ST_IDLE;
        end else begin
          state_nxt = ST_PRE_CMP;
        end
      end
      ST_PRE_CMP: begin
        if (rid_rdata == tgt_r) begin
          state_nxt = last_r ? ST_NU_I : ST_IDLE;
        end else begin
          s_nxt     = s_r + 1'b1;
          state_nxt = ST_PRE_CHK;
        end
      end

      // next use of each access
      ST_NU_I: begin
        if (i_r == len_r) begin
          s_nxt     = '0;
          state_nxt = ST_RN_S;
        end else begin
          state_nxt = ST_NU_ID;
        end
      end
      ST_NU_ID: begin
        tgt_nxt   = acc_rdata;
        j_nxt     = i_r + 1'b1;
        mode_nxt  = 1'b0;
        state_nxt = ST_NU_J;
      end

      // shared forward search for tgt from j
      ST_NU_J: begin
        acc_raddr = j_r[SA-1:0];
        if (j_r == len_r) begin
          scan_val = len_r;
          if (mode_r) begin
            rnu_we    = 1'b1;
            rnu_wdata = scan_val;
            s_nxt     = s_r + 1'b1;
            state_nxt = ST_RN_S;
          end else begin
            nu_we     = 1'b1;
            nu_wdata  = scan_val;
            i_nxt     = i_r + 1'b1;
            state_nxt = ST_NU_I;
          end
        end else begin
          state_nxt = ST_NU_JC;
        end
      end
      ST_NU_JC: begin
        if (acc_rdata == tgt_r) begin
          scan_val = j_r;
          if (mode_r) begin
            rnu_we    = 1'b1;
            rnu_wdata = scan_val;
            s_nxt     = s_r + 1'b1;
            state_nxt = ST_RN_S;
          end else begin
            nu_we     = 1'b1;
            nu_wdata  = scan_val;
            i_nxt     = i_r + 1'b1;
            state_nxt = ST_NU_I;
          end
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_NU_J;
        end
      end

      // first use of each resident entry
      ST_RN_S: begin
        if (s_r == occ_r) begin
          i_nxt     = '0;
          state_nxt = ST_RP_I;
        end else begin
          state_nxt = ST_RN_ID;
        end
      end
      ST_RN_ID: begin
        tgt_nxt   = rid_rdata;
        j_nxt     = '0;
        mode_nxt  = 1'b1;
        state_nxt = ST_NU_J;
      end

      // replay of the sequence
      ST_RP_I: begin
        if (i_r == len_r) begin
          ov_nxt    = 1'b1;
          omc_nxt   = tally_r;
          oof_nxt   = ovf_r;
          occ_nxt   = '0;
          len_nxt   = '0;
          tally_nxt = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_RP_ID;
        end
      end
      ST_RP_ID: begin
        tgt_nxt    = acc_rdata;
        cur_nu_nxt = nu_rdata;
        s_nxt      = '0;
        state_nxt  = ST_RP_F;
      end
      ST_RP_F: begin
        if (s_r == occ_r) begin
          if (KW'(occ_r) < cap_eff) begin
            rid_we    = 1'b1;
            rnu_we    = 1'b1;
            rnu_waddr = occ_r[CA-1:0];
            occ_nxt   = occ_r + 1'b1;
            i_nxt     = i_r + 1'b1;
            state_nxt = ST_RP_I;
          end else begin
            s_nxt     = '0;
            have_nxt  = 1'b0;
            state_nxt = ST_RP_M;
          end
        end else begin
          state_nxt = ST_RP_FC;
        end
      end
      ST_RP_FC: begin
        if (rid_rdata == tgt_r) begin
          rnu_we    = 1'b1;
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_RP_I;
        end else begin
          s_nxt     = s_r + 1'b1;
          state_nxt = ST_RP_F;
        end
      end

      // farthest next use, lowest slot on ties
      ST_RP_M: begin
        if (s_r == occ_r) begin
          rid_we    = 1'b1;
          rid_waddr = best_r;
          rnu_we    = 1'b1;
          rnu_waddr = best_r;
          if (tally_r != TALLY_MAX) begin
            tally_nxt = tally_r + 1'b1;
          end
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_RP_I;
        end else begin
          state_nxt = ST_RP_MC;
        end
      end
      ST_RP_MC: begin
        if (!have_r || (rnu_rdata > far_r)) begin
          best_nxt = s_r[CA-1:0];
          far_nxt  = rnu_rdata;
          have_nxt = 1'b1;
        end
        s_nxt     = s_r + 1'b1;
        state_nxt = ST_RP_M;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      occ_r   <= '0;
      len_r   <= '0;
      tally_r <= '0;
      ovf_r   <= 1'b0;
      ov_r    <= 1'b0;
      cap_r   <= CAP_RESET;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      len_r   <= len_nxt;
      tally_r <= tally_nxt;
      ovf_r   <= ovf_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    s_r      <= s_nxt;
    best_r   <= best_nxt;
    far_r    <= far_nxt;
    cur_nu_r <= cur_nu_nxt;
    tgt_r    <= tgt_nxt;
    have_r   <= have_nxt;
    mode_r   <= mode_nxt;
    last_r   <= last_nxt;
    omc_r    <= omc_nxt;
    oof_r    <= oof_nxt;
  end

  assign out_valid      = ov_r;
  assign out_miss_count = omc_r;
  assign out_overflow   = oof_r;

endmodule

/* bench/optimal_cache_miss_counter_core_tb.sv */
`timescale 1ns / 100ps

module optimal_cache_miss_counter_core_tb;
  import ocmc_pkg::*;

  localparam int SEQ_D   = 1024;
  localparam int CACHE_D = 64;
  localparam int WATCH_LIMIT = 10000000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_command;
  logic [31:0] in_item_id;
  logic        in_last;
  logic        out_valid;
  logic [10:0] out_miss_count;
  logic        out_overflow;
  logic        cfg_we;
  logic [6:0]  cfg_wdata;

  optimal_cache_miss_counter_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_item_id(in_item_id), .in_last(in_last),
    .out_valid(out_valid), .out_miss_count(out_miss_count),
    .out_overflow(out_overflow), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  typedef struct packed {
    logic [10:0] miss_count;
    logic        overflow;
  } tally_t;

  // predictor state
  logic [31:0] seq_ids [SEQ_D];
  logic [31:0] held_ids [CACHE_D];
  logic        held_ok [CACHE_D];
  int          held_cnt;
  int          seq_len;
  logic        lost;
  logic [6:0]  capacity;
  tally_t      tally_q[$];
  int          err_cnt;
  int          idle_cycles;
  int          burst_left;

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  task automatic report(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  function automatic int next_ref(input logic [31:0] id, input int from);
    for (int j = from; j < seq_len; j++)
      if (seq_ids[j] == id) return j;
    return seq_len;
  endfunction

  // farthest-in-future replay over the collected job
  function automatic tally_t belady_tally();
    int          nxt [SEQ_D];
    int          res_nxt [CACHE_D];
    int          cap;
    int          occ;
    int          slot;
    int          far;
    int          evict;
    tally_t      r;
    cap = (capacity == 0) ? 1 : ((capacity > CACHE_D) ? CACHE_D : capacity);
    occ = held_cnt;
    evict = 0;
    for (int i = 0; i < seq_len; i++) nxt[i] = next_ref(seq_ids[i], i + 1);
    for (int s = 0; s < CACHE_D; s++) res_nxt[s] = held_ok[s] ? next_ref(held_ids[s], 0) : 0;
    for (int i = 0; i < seq_len; i++) begin
      slot = -1;
      for (int s = 0; s < CACHE_D; s++)
        if (slot < 0 && held_ok[s] && held_ids[s] == seq_ids[i]) slot = s;
      if (slot < 0) begin
        if (occ < cap) begin
          for (int s = 0; s < CACHE_D; s++)
            if (slot < 0 && !held_ok[s]) slot = s;
          if (slot < 0) slot = 0;
          occ++;
        end else begin
          far = 0;
          for (int s = 0; s < CACHE_D; s++)
            if (held_ok[s] && (slot < 0 || res_nxt[s] > far)) begin
              slot = s;
              far = res_nxt[s];
            end
          if (slot < 0) slot = 0;
          if (evict < 2047) evict++;
        end
        held_ok[slot] = 1'b1;
        held_ids[slot] = seq_ids[i];
      end
      res_nxt[slot] = nxt[i];
    end
    r.miss_count = evict[10:0];
    r.overflow = lost;
    return r;
  endfunction

  function automatic void clear_job();
    for (int s = 0; s < CACHE_D; s++) held_ok[s] = 1'b0;
    held_cnt = 0;
    seq_len = 0;
    lost = 1'b0;
  endfunction

  function automatic void predict(input logic cmd, input logic [31:0] id, input logic lst);
    logic hit;
    logic done;
    if (cmd == CMD_PRELOAD) begin
      hit = 1'b0;
      for (int s = 0; s < CACHE_D; s++) if (held_ok[s] && held_ids[s] == id) hit = 1'b1;
      if (!hit) begin
        if (held_cnt >= CACHE_D) lost = 1'b1;
        else begin
          done = 1'b0;
          for (int s = 0; s < CACHE_D; s++)
            if (!done && !held_ok[s]) begin
              held_ok[s] = 1'b1;
              held_ids[s] = id;
              held_cnt++;
              done = 1'b1;
            end
        end
      end
    end else begin
      if (seq_len >= SEQ_D) lost = 1'b1;
      else begin
        seq_ids[seq_len] = id;
        seq_len++;
      end
    end
    if (lst) begin
      tally_q = {tally_q, belady_tally()};
      clear_job();
    end
  endfunction

  // send one item; items come in bursts with optional sender gaps between them
  task automatic send_item(input logic cmd, input logic [31:0] id, input logic lst);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    start <= 1'b1;
    in_command <= cmd;
    in_item_id <= id;
    in_last <= lst;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict(cmd, id, lst);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (tally_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [6:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    capacity = v;
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (tally_q.size() == 0) report("unexpected result", out_miss_count, -1);
      else begin
        tally_t e;
        e = tally_q.pop_front();
        if (out_miss_count !== e.miss_count) report("miss_count", out_miss_count, e.miss_count);
        if (out_overflow !== e.overflow) report("overflow", out_overflow, e.overflow);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCH_LIMIT) begin
      $display("optimal_cache_miss_counter_core_tb: done, errors");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(CMD_ACCESS, 32'h0, 1'b1);
    send_item(CMD_PRELOAD, 32'hFFFF_FFFF, 1'b1);
    send_item(CMD_PRELOAD, 32'h5, 1'b0);
    send_item(CMD_PRELOAD, 32'h5, 1'b0);
    send_item(CMD_PRELOAD, 32'h9, 1'b0);
    send_item(CMD_ACCESS, 32'h1, 1'b0);
    send_item(CMD_ACCESS, 32'h5, 1'b0);
    send_item(CMD_ACCESS, 32'h2, 1'b0);
    send_item(CMD_ACCESS, 32'h1, 1'b0);
    send_item(CMD_ACCESS, 32'hFFFF_FFFF, 1'b0);
    send_item(CMD_ACCESS, 32'h0, 1'b1);
  endtask

  task automatic test_capacity_extremes();
    logic [6:0] caps [5] = '{7'd0, 7'd1, 7'd127, 7'd65, 7'd64};
    foreach (caps[k]) begin
      set_capacity(caps[k]);
      send_item(CMD_PRELOAD, 32'h3, 1'b0);
      for (int i = 0; i < 6; i++) send_item(CMD_ACCESS, 32'(i % 4), i == 5);
    end
  endtask

  // preload store fills up, then an oversize access sequence
  task automatic test_overflow();
    set_capacity(7'd2);
    for (int i = 0; i < CACHE_D + 2; i++) send_item(CMD_PRELOAD, 32'(i), 1'b0);
    send_item(CMD_ACCESS, 32'h7, 1'b1);
    set_capacity(7'd1);
    for (int i = 0; i < SEQ_D + 1; i++) send_item(CMD_ACCESS, $urandom_range(0, 3), 1'b0);
    send_item(CMD_ACCESS, 32'h1, 1'b1);
  endtask

  task automatic test_random();
    int items;
    int len;
    int pool;
    logic [31:0] base;
    items = 0;
    while (items < 510) begin
      if ($urandom_range(0, 7) == 0) set_capacity(7'($urandom_range(0, 127)));
      if ($urandom_range(0, 9) == 0) drain();
      pool = $urandom_range(1, 12);
      base = $urandom;
      for (int p = $urandom_range(0, 5); p > 0; p--) begin
        send_item(CMD_PRELOAD, base ^ $urandom_range(0, pool), 1'b0);
        items++;
      end
      len = $urandom_range(0, 24);
      for (int i = 0; i < len; i++) begin
        send_item(CMD_ACCESS, ($urandom_range(0, 15) == 0) ? $urandom
                  : base ^ $urandom_range(0, pool), 1'b0);
        items++;
      end
      send_item(1'($urandom_range(0, 1)), base ^ $urandom_range(0, pool), 1'b1);
      items++;
    end
  endtask

  initial begin
    start = 1'b0; in_command = 1'b0; in_item_id = '0; in_last = 1'b0;
    cfg_we = 1'b0; cfg_wdata = '0;
    err_cnt = 0; burst_left = 0;
    capacity = CAP_RESET;
    clear_job();
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_capacity_extremes();
    test_overflow();
    test_random();
    drain();
    if (err_cnt == 0) $display("optimal_cache_miss_counter_core_tb: done, clean");
    else $display("optimal_cache_miss_counter_core_tb: done, errors");
    $finish;
  end

endmodule
